/* sv/sxfb_pkg.sv */
// ----------------------------------------------------------------------------
// sxfb_pkg
// Shared types and constants for the sprite XOR framebuffer.
// ----------------------------------------------------------------------------
package sxfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam int ROW_BITS    = 64;
  localparam int SPRITE_BITS = 8;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]             command;
    logic [5:0]             x_pos;
    logic [4:0]             y_pos;
    logic [SPRITE_BITS-1:0] sprite_byte;
    logic                   first_row;
  } cmd_item_t;

  typedef struct packed {
    logic                collision;
    logic [ROW_BITS-1:0] row_data;
  } res_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

/* sv/sxfb_ram.sv */
// ----------------------------------------------------------------------------
// sxfb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sxfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sprite_xor_framebuffer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_unit
// Monochrome framebuffer with XOR sprite drawing, clear and row read-back.
// ----------------------------------------------------------------------------
// Each item is one command and gives exactly one result item. An item first
// reads the addressed row from the row RAM as it is accepted; then, in the
// execute state, the shared mask/XOR unit updates the row, writes it back on
// an in-range draw and loads the result register, waiting while the previous
// result has not been taken. Clearing the screen leaves the row RAM alone:
// every row has a valid bit and clear drops them all, so invalid rows read as
// zero. Rows at or beyond the screen height are never drawn and read as zero.
module sprite_xor_framebuffer_unit
  import sxfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  localparam int ROW_AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam logic [6:0] HEIGHT_LIM = 7'(SCREEN_HEIGHT);
  localparam logic [ROW_BITS-1:0] WIDTH_MASK = ~({ROW_BITS{1'b1}} >> SCREEN_WIDTH);

  state_t state, state_next;

  cmd_item_t cur;
  logic      cur_in_range;
  logic      cur_valid;
  logic      collision_seen, collision_next;
  logic [SCREEN_HEIGHT-1:0] row_valid;

  logic [6:0]          y_ext;
  logic [ROW_AW-1:0]   y_addr;
  logic [6:0]          cur_y_ext;
  logic [ROW_AW-1:0]   cur_addr;
  logic                accept;
  logic                slot_free;
  logic                finish;
  logic                ram_we;
  logic [ROW_BITS-1:0] ram_rdata;
  logic [ROW_BITS-1:0] row_old;
  logic [ROW_BITS-1:0] sprite_mask;
  logic [ROW_BITS-1:0] row_new;
  logic                hit;

  assign y_ext     = {2'b00, cmd.y_pos};
  assign y_addr    = y_ext[ROW_AW-1:0];
  assign cur_y_ext = {2'b00, cur.y_pos};
  assign cur_addr  = cur_y_ext[ROW_AW-1:0];

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign slot_free = !res_valid || res_ready;
  assign finish    = (state == S_EXEC) && slot_free;

  sxfb_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (SCREEN_HEIGHT)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata (row_new),
    .re    (accept),
    .raddr (y_addr),
    .rdata (ram_rdata)
  );

  // Shared mask and XOR unit: the sprite byte lands MSB first at x_pos, and
  // anything past the right edge of the screen is clipped away.
  always_comb begin
    row_old     = cur_valid ? ram_rdata : '0;
    sprite_mask = ({cur.sprite_byte, {(ROW_BITS - SPRITE_BITS){1'b0}}} >> cur.x_pos)
                  & WIDTH_MASK;
    hit         = |(row_old & sprite_mask);
    row_new     = row_old ^ sprite_mask;
  end

  assign ram_we = finish && (cur.command == CMD_DRAW) && cur_in_range;

  always_comb begin
    collision_next = collision_seen;
    if (cur.command == CMD_DRAW) begin
      if (cur.first_row) begin
        collision_next = 1'b0;
      end
      if (cur_in_range && hit) begin
        collision_next = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur          <= cmd;
      cur_in_range <= (y_ext < HEIGHT_LIM);
      cur_valid    <= row_valid[y_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      collision_seen <= 1'b0;
    end else if (finish) begin
      collision_seen <= collision_next;
      if (cur.command == CMD_CLEAR) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[cur_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res.collision <= collision_next;
      res.row_data  <= ((cur.command == CMD_READ) && cur_in_range) ? row_old : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item did not move the sequencer to execute");

  a_hold_exec: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && !slot_free) |=> (state == S_EXEC))
    else $error("sequencer left execute while the result register was full");

  a_write_draw: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_EXEC) && (cur.command == CMD_DRAW) && cur_in_range))
    else $error("row write outside an in-range draw");

  a_zero_row: assert property (@(posedge clk) disable iff (rst)
    (finish && (cur.command != CMD_READ)) |=> (res.row_data == '0))
    else $error("non-read item gave non-zero row data");
`endif

endmodule
